@@ sv/fdr_pkg.sv @@
// fdr_pkg: types, register codes and field widths for frame_dirty_rectangle.
// No dependencies; imported by the top level.
`default_nettype none
package fdr_pkg;

  localparam int DEF_MAX_WIDTH  = 4096;
  localparam int DEF_MAX_HEIGHT = 4096;

  localparam int PIXEL_W    = 32;
  localparam int CFG_DIM_W  = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int START_W    = 12;
  localparam int END_W      = 13;

  localparam logic [CFG_DIM_W-1:0] RESET_FRAME_WIDTH  = 13'd640;
  localparam logic [CFG_DIM_W-1:0] RESET_FRAME_HEIGHT = 13'd480;
  // alpha byte left out of the compare
  localparam logic [PIXEL_W-1:0]   RESET_COMPARE_MASK = 32'h00FF_FFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1,
    CFG_COMPARE_MASK = 2'd2
  } cfg_index_t;

  typedef struct packed {
    logic [PIXEL_W-1:0] old_pixel;
    logic [PIXEL_W-1:0] new_pixel;
  } pixel_pair_t;

  typedef struct packed {
    logic               changed;
    logic [START_W-1:0] x_start;
    logic [START_W-1:0] y_start;
    logic [END_W-1:0]   x_end;
    logic [END_W-1:0]   y_end;
  } rect_t;

endpackage
`default_nettype wire

@@ sv/frame_dirty_rectangle.sv @@
// frame_dirty_rectangle: bounding box of changed pixels between two frames.
// Depends on fdr_pkg.
//
// Usage:
//   pix channel: one pixel pair (previous, current) per transaction, in
//   raster order. Column and row are counted internally from frame_width
//   and frame_height (0 acts as 1, values above MAX_WIDTH/MAX_HEIGHT
//   saturate).
//   rect channel: one transaction per frame, issued after the last pixel:
//   changed flag and rectangle with exclusive ends, all zero if unchanged.
//   cfg channel: register writes, always ready; index 0 width, 1 height,
//   2 compare mask. Other indexes are ignored.
// Timing:
//   One pixel pair per cycle sustained; each pair updates the box in the
//   cycle it is taken. The result is registered and appears in the cycle
//   after the last pixel of the frame is taken.
//   While a result waits, pixels keep flowing; only the last pixel of the
//   next frame is held off (pix_ready low) until rect_ready takes the
//   pending result.
// Reset:
//   rst (synchronous) restores 640 x 480, mask 0x00FFFFFF, and starts a
//   new frame at column 0, row 0 with no result pending.
`default_nettype none
module frame_dirty_rectangle #(
  parameter int MAX_WIDTH  = fdr_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = fdr_pkg::DEF_MAX_HEIGHT
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             pix_valid,
  output logic                                  pix_ready,
  input  wire fdr_pkg::pixel_pair_t             pix_data,
  output logic                                  rect_valid,
  input  wire logic                             rect_ready,
  output fdr_pkg::rect_t                        rect_data,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [fdr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [fdr_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import fdr_pkg::*;

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int RW   = $clog2(MAX_HEIGHT);
  localparam int CWX  = (CW + 1 > CFG_DIM_W) ? CW + 1 : CFG_DIM_W;
  localparam int RWX  = (RW + 1 > CFG_DIM_W) ? RW + 1 : CFG_DIM_W;

  logic [CFG_DIM_W-1:0] frame_width;
  logic [CFG_DIM_W-1:0] frame_height;
  logic [PIXEL_W-1:0]   compare_mask;

  logic [CW-1:0] column_count;
  logic [RW-1:0] row_count;
  logic [CW-1:0] min_column;
  logic [CW-1:0] max_column;
  logic [RW-1:0] min_row;
  logic [RW-1:0] max_row;
  logic          any_difference;

  logic [CWX-1:0] width_eff;
  logic [RWX-1:0] height_eff;
  logic [CWX-1:0] column_inc;
  logic [RWX-1:0] row_inc;
  logic           row_last;
  logic           frame_last;
  logic           pix_fire;
  logic           diff;
  logic           rect_valid_next;
  rect_t          rect_next;

  // effective dimensions
  always_comb begin
    width_eff = CWX'(frame_width);
    if (frame_width == '0) begin
      width_eff = CWX'(1);
    end else if (width_eff > CWX'(MAX_WIDTH)) begin
      width_eff = CWX'(MAX_WIDTH);
    end
    height_eff = RWX'(frame_height);
    if (frame_height == '0) begin
      height_eff = RWX'(1);
    end else if (height_eff > RWX'(MAX_HEIGHT)) begin
      height_eff = RWX'(MAX_HEIGHT);
    end
  end

  assign column_inc = CWX'(column_count) + CWX'(1);
  assign row_inc    = RWX'(row_count) + RWX'(1);
  assign row_last   = !(column_inc < width_eff);
  assign frame_last = row_last && !(row_inc < height_eff);

  assign cfg_ready  = 1'b1;
  assign pix_ready  = !frame_last || !rect_valid || rect_ready;
  assign pix_fire   = pix_valid && pix_ready;
  assign diff       = |((pix_data.old_pixel ^ pix_data.new_pixel) & compare_mask);

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= RESET_FRAME_WIDTH;
      frame_height <= RESET_FRAME_HEIGHT;
      compare_mask <= RESET_COMPARE_MASK;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_FRAME_WIDTH:  frame_width  <= cfg_data[CFG_DIM_W-1:0];
        CFG_FRAME_HEIGHT: frame_height <= cfg_data[CFG_DIM_W-1:0];
        CFG_COMPARE_MASK: compare_mask <= cfg_data[PIXEL_W-1:0];
        default: ;
      endcase
    end
  end

  // box tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count   <= '0;
      row_count      <= '0;
      min_column     <= CW'(MAX_WIDTH - 1);
      max_column     <= '0;
      min_row        <= RW'(MAX_HEIGHT - 1);
      max_row        <= '0;
      any_difference <= 1'b0;
    end else if (pix_fire) begin
      if (frame_last) begin
        column_count   <= '0;
        row_count      <= '0;
        min_column     <= CW'(MAX_WIDTH - 1);
        max_column     <= '0;
        min_row        <= RW'(MAX_HEIGHT - 1);
        max_row        <= '0;
        any_difference <= 1'b0;
      end else begin
        if (diff) begin
          any_difference <= 1'b1;
          if (!any_difference) begin
            min_column <= column_count;
            max_column <= column_count;
            min_row    <= row_count;
            max_row    <= row_count;
          end else begin
            if (column_count < min_column) min_column <= column_count;
            if (column_count > max_column) max_column <= column_count;
            if (row_count < min_row) min_row <= row_count;
            if (row_count > max_row) max_row <= row_count;
          end
        end
        if (row_last) begin
          column_count <= '0;
          row_count    <= row_inc[RW-1:0];
        end else begin
          column_count <= column_inc[CW-1:0];
        end
      end
    end
  end

  // result of the closing pixel, folding in its own difference
  always_comb begin
    logic [CW-1:0] lo_c;
    logic [CW-1:0] hi_c;
    logic [RW-1:0] lo_r;
    logic [RW-1:0] hi_r;
    logic [31:0]   x_end_w;
    logic [31:0]   y_end_w;
    lo_c = min_column;
    hi_c = max_column;
    lo_r = min_row;
    hi_r = max_row;
    if (diff) begin
      if (!any_difference) begin
        lo_c = column_count;
        hi_c = column_count;
        lo_r = row_count;
        hi_r = row_count;
      end else begin
        if (column_count < min_column) lo_c = column_count;
        if (column_count > max_column) hi_c = column_count;
        if (row_count < min_row) lo_r = row_count;
        if (row_count > max_row) hi_r = row_count;
      end
    end
    x_end_w = 32'(hi_c) + 32'd1;
    y_end_w = 32'(hi_r) + 32'd1;
    rect_next = '0;
    if (diff || any_difference) begin
      rect_next.changed = 1'b1;
      rect_next.x_start = START_W'(32'(lo_c));
      rect_next.y_start = START_W'(32'(lo_r));
      rect_next.x_end   = x_end_w[END_W-1:0];
      rect_next.y_end   = y_end_w[END_W-1:0];
    end
  end

  assign rect_valid_next = (rect_valid && !rect_ready) || (pix_fire && frame_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      rect_valid <= 1'b0;
    end else begin
      rect_valid <= rect_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_fire && frame_last) begin
      rect_data <= rect_next;
    end
  end

  a_unchanged_zero: assert property (@(posedge clk) disable iff (rst)
    rect_valid && !rect_data.changed |->
      rect_data.x_start == '0 && rect_data.y_start == '0 &&
      rect_data.x_end == '0 && rect_data.y_end == '0)
    else $error("unchanged frame with nonzero rectangle");

  a_box_ordered: assert property (@(posedge clk) disable iff (rst)
    any_difference |-> min_column <= max_column && min_row <= max_row)
    else $error("bounding box inverted");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    pix_fire && frame_last |-> !rect_valid || rect_ready)
    else $error("pending result overwritten");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    pix_fire && frame_last |=> rect_valid && column_count == '0 && row_count == '0)
    else $error("frame end without result or counter restart");

endmodule
`default_nettype wire
